>>> src/aefr_pkg.sv
// Shared types and constants for the absolute-encoder frame receiver.
// No dependencies; every other file of the block but aefr_if imports this package.
package aefr_pkg;

  // Frame lengths and reset command repeat count
  localparam int unsigned LONG_FRAME_BYTES  = 11;
  localparam int unsigned SHORT_FRAME_BYTES = 6;
  localparam logic [3:0]  LONG_LEN          = 4'd11;
  localparam logic [3:0]  SHORT_LEN         = 4'd6;
  localparam logic [3:0]  NO_LEN            = 4'd0;
  localparam logic [3:0]  RESET_LEN         = 4'd5;
  localparam logic [3:0]  RESET_REPEATS     = 4'd10;
  localparam logic [3:0]  BYTE_COUNT_MAX    = 4'd15;

  // Request command bytes
  localparam logic [7:0] CMD_READ    = 8'h1A;
  localparam logic [7:0] CMD_RESET_A = 8'hBA;
  localparam logic [7:0] CMD_RESET_B = 8'h62;
  localparam logic [7:0] CMD_RESET_C = 8'hC2;

  // Item operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Request selection codes
  localparam logic [2:0] CODE_READ    = 3'd0;
  localparam logic [2:0] CODE_RESET_A = 3'd1;
  localparam logic [2:0] CODE_RESET_B = 3'd2;
  localparam logic [2:0] CODE_RESET_C = 3'd3;

  // Register indexes (byte address bits [3:2])
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam logic [1:0]  REG_PERIOD   = 2'd0;
  localparam logic [1:0]  REG_NOACK    = 2'd1;
  localparam logic [1:0]  REG_CRCLIM   = 2'd2;

  // Register reset values
  localparam logic [15:0] PERIOD_RST = 16'd1;
  localparam logic [7:0]  NOACK_RST  = 8'd3;
  localparam logic [7:0]  CRCLIM_RST = 8'd3;

  // Configuration handed from the register block to the core
  typedef struct packed {
    logic [15:0] period_ticks;
    logic [7:0]  no_ack_limit;
    logic [7:0]  crc_limit;
  } aefr_cfg_t;

  // One result item
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_command;
    logic        frame_good;
    logic [23:0] abs_position;
    logic [15:0] multi_turn;
    logic [7:0]  status_byte;
    logic [7:0]  alarm_byte;
    logic        crc_error_flag;
    logic        no_ack_flag;
    logic        reset_done;
    logic [15:0] crc_error_total;
    logic [15:0] no_ack_total;
  } aefr_result_t;

endpackage

>>> src/aefr_if.sv
// Valid/ready channel interfaces for the frame receiver's input and result items.
// No dependencies.
interface aefr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  logic [2:0] reset_code;

  modport source (output valid, operation, rx_byte, reset_code, input ready);
  modport sink   (input valid, operation, rx_byte, reset_code, output ready);
endinterface

interface aefr_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_command;
  logic        frame_good;
  logic [23:0] abs_position;
  logic [15:0] multi_turn;
  logic [7:0]  status_byte;
  logic [7:0]  alarm_byte;
  logic        crc_error_flag;
  logic        no_ack_flag;
  logic        reset_done;
  logic [15:0] crc_error_total;
  logic [15:0] no_ack_total;

  modport source (output valid, tx_valid, tx_command, frame_good, abs_position, multi_turn,
                  status_byte, alarm_byte, crc_error_flag, no_ack_flag, reset_done,
                  crc_error_total, no_ack_total, input ready);
  modport sink   (input valid, tx_valid, tx_command, frame_good, abs_position, multi_turn,
                  status_byte, alarm_byte, crc_error_flag, no_ack_flag, reset_done,
                  crc_error_total, no_ack_total, output ready);
endinterface

>>> src/aefr_regs.sv
// APB-style configuration registers of the frame receiver.
// Depends on aefr_pkg.
module aefr_regs
  import aefr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output aefr_cfg_t             cfg
);

  aefr_cfg_t  cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ticks <= PERIOD_RST;
      cfg_r.no_ack_limit <= NOACK_RST;
      cfg_r.crc_limit    <= CRCLIM_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PERIOD: cfg_r.period_ticks <= pwdata[15:0];
        REG_NOACK:  cfg_r.no_ack_limit <= pwdata[7:0];
        REG_CRCLIM: cfg_r.crc_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_PERIOD: prdata = {16'd0, cfg_r.period_ticks};
      REG_NOACK:  prdata = {24'd0, cfg_r.no_ack_limit};
      REG_CRCLIM: prdata = {24'd0, cfg_r.crc_limit};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

>>> src/aefr_core.sv
// Reply buffer, tick timer, frame check, error runs and request sequencing.
// Depends on aefr_pkg; state is updated at the edge an item is accepted.
module aefr_core
  import aefr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  aefr_cfg_t    cfg,
  input  logic         item_en,
  input  logic         operation,
  input  logic [7:0]   rx_byte,
  input  logic [2:0]   reset_code,
  output logic         res_valid,
  output aefr_result_t res
);

  logic [7:0]  buf_r [LONG_FRAME_BYTES];
  logic [3:0]  byte_cnt_r, exp_len_r, rst_cnt_r;
  logic [15:0] tick_r;
  logic [7:0]  noack_run_r, fail_run_r;
  logic [15:0] noack_tot_r, fail_tot_r;
  logic [23:0] pos_r;
  logic [15:0] turns_r;
  logic [7:0]  status_r, alarm_r;

  logic [3:0]  byte_cnt_nxt, exp_len_nxt, rst_cnt_nxt;
  logic [15:0] tick_nxt, tick_inc;
  logic [7:0]  noack_run_nxt, fail_run_nxt;
  logic [15:0] noack_tot_nxt, fail_tot_nxt;
  logic [23:0] pos_nxt;
  logic [15:0] turns_nxt;
  logic [7:0]  status_nxt, alarm_nxt;

  logic        is_byte, is_tick, fire;
  logic [7:0]  xor_long, xor_short;
  logic        chk_long, chk_short, len_ok, checked, good, noack_ev, fail_ev;
  logic        tx_valid, done;
  logic [7:0]  cmd;
  logic [3:0]  rst_inc;

  assign is_byte = item_en & (operation == OP_BYTE);
  assign is_tick = item_en & (operation == OP_TICK);

  // Reply buffer: bytes past the long frame are dropped
  always_ff @(posedge clk) begin
    if (is_byte && byte_cnt_r < LONG_LEN) begin
      buf_r[byte_cnt_r] <= rx_byte;
    end
  end

  // Check bytes of both frame lengths
  assign xor_short = buf_r[0] ^ buf_r[1] ^ buf_r[2] ^ buf_r[3] ^ buf_r[4];
  assign xor_long  = xor_short ^ buf_r[5] ^ buf_r[6] ^ buf_r[7] ^ buf_r[8] ^ buf_r[9];
  assign chk_short = (xor_short == buf_r[SHORT_FRAME_BYTES-1]);
  assign chk_long  = (xor_long == buf_r[LONG_FRAME_BYTES-1]);

  // Evaluation of the buffered reply
  assign tick_inc = tick_r + 16'd1;
  assign fire     = is_tick & (tick_inc == cfg.period_ticks);
  assign checked  = (exp_len_r != NO_LEN);
  assign len_ok   = (byte_cnt_r == exp_len_r);
  assign good     = checked & len_ok &
                    (((exp_len_r == LONG_LEN) & chk_long) |
                     ((exp_len_r == SHORT_LEN) & chk_short));
  assign noack_ev = checked & ~len_ok;
  assign fail_ev  = checked & len_ok & ~good;
  assign rst_inc  = rst_cnt_r + 4'd1;

  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    tick_nxt      = tick_r;
    exp_len_nxt   = exp_len_r;
    rst_cnt_nxt   = rst_cnt_r;
    noack_run_nxt = noack_run_r;
    fail_run_nxt  = fail_run_r;
    noack_tot_nxt = noack_tot_r;
    fail_tot_nxt  = fail_tot_r;
    pos_nxt       = pos_r;
    turns_nxt     = turns_r;
    status_nxt    = status_r;
    alarm_nxt     = alarm_r;
    tx_valid      = 1'b0;
    cmd           = 8'd0;
    done          = 1'b0;

    if (is_byte && byte_cnt_r != BYTE_COUNT_MAX) begin
      byte_cnt_nxt = byte_cnt_r + 4'd1;
    end

    if (is_tick) begin
      tick_nxt = fire ? 16'd0 : tick_inc;
    end

    if (fire) begin
      byte_cnt_nxt = 4'd0;
      // Runs and totals
      if (noack_ev) begin
        if (noack_run_r != 8'hFF) noack_run_nxt = noack_run_r + 8'd1;
        noack_tot_nxt = noack_tot_r + 16'd1;
      end
      if (checked && len_ok) noack_run_nxt = 8'd0;
      if (fail_ev) begin
        if (fail_run_r != 8'hFF) fail_run_nxt = fail_run_r + 8'd1;
        fail_tot_nxt = fail_tot_r + 16'd1;
      end
      if (good) fail_run_nxt = 8'd0;
      // Frame fields
      if (good) begin
        status_nxt = buf_r[1];
        if (exp_len_r == LONG_LEN) begin
          pos_nxt   = {buf_r[4], buf_r[3], buf_r[2]};
          turns_nxt = {buf_r[7], buf_r[6]};
          alarm_nxt = buf_r[9];
        end
      end
      // Next request
      case (reset_code)
        CODE_READ: begin
          tx_valid    = 1'b1;
          cmd         = CMD_READ;
          exp_len_nxt = LONG_LEN;
        end
        CODE_RESET_A, CODE_RESET_B, CODE_RESET_C: begin
          tx_valid    = 1'b1;
          case (reset_code)
            CODE_RESET_A: cmd = CMD_RESET_A;
            CODE_RESET_B: cmd = CMD_RESET_B;
            default:      cmd = CMD_RESET_C;
          endcase
          exp_len_nxt = SHORT_LEN;
          if (rst_inc == RESET_REPEATS) begin
            rst_cnt_nxt = 4'd0;
            done        = 1'b1;
          end else begin
            rst_cnt_nxt = rst_inc;
          end
        end
        default: exp_len_nxt = NO_LEN;
      endcase
    end
  end

  // Result item built from the updated state
  assign res_valid           = fire;
  assign res.tx_valid        = tx_valid;
  assign res.tx_command      = cmd;
  assign res.frame_good      = good;
  assign res.abs_position    = pos_nxt;
  assign res.multi_turn      = turns_nxt;
  assign res.status_byte     = status_nxt;
  assign res.alarm_byte      = alarm_nxt;
  assign res.crc_error_flag  = (fail_run_nxt >= cfg.crc_limit);
  assign res.no_ack_flag     = (noack_run_nxt >= cfg.no_ack_limit);
  assign res.reset_done      = done;
  assign res.crc_error_total = fail_tot_nxt;
  assign res.no_ack_total    = noack_tot_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= 4'd0;
      exp_len_r   <= RESET_LEN;
      tick_r      <= 16'd0;
      rst_cnt_r   <= 4'd0;
      noack_run_r <= 8'd0;
      fail_run_r  <= 8'd0;
      noack_tot_r <= 16'd0;
      fail_tot_r  <= 16'd0;
      pos_r       <= 24'd0;
      turns_r     <= 16'd0;
      status_r    <= 8'd0;
      alarm_r     <= 8'd0;
    end else begin
      byte_cnt_r  <= byte_cnt_nxt;
      exp_len_r   <= exp_len_nxt;
      tick_r      <= tick_nxt;
      rst_cnt_r   <= rst_cnt_nxt;
      noack_run_r <= noack_run_nxt;
      fail_run_r  <= fail_run_nxt;
      noack_tot_r <= noack_tot_nxt;
      fail_tot_r  <= fail_tot_nxt;
      pos_r       <= pos_nxt;
      turns_r     <= turns_nxt;
      status_r    <= status_nxt;
      alarm_r     <= alarm_nxt;
    end
  end

endmodule

>>> src/abs_encoder_frame_receiver.sv
// Top level of the absolute-encoder frame receiver: core, registers, result queue.
// Depends on aefr_pkg, aefr_if, aefr_regs and aefr_core.
//
//   channel   direction  handshake            payload
//   in_ch     sink       valid/ready          operation, rx_byte, reset_code
//   out_ch    source     valid/ready          request, frame status, position, counters
//   psel..    APB slave  psel/penable/pready  period_ticks, no_ack_limit, crc_limit
//
// One item per cycle: every item is handled in the cycle it is accepted; a timer
// tick that completes a period puts its result in the output register, or in the
// skid entry if out_ch stalls. A two-entry result queue (output register plus skid)
// lets items keep flowing; in_ch.ready drops only while the skid entry is occupied.
// Reset (rst_n, synchronous) clears all control state and both queue entries.
module abs_encoder_frame_receiver
  import aefr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  aefr_in_if.sink               in_ch,
  aefr_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  aefr_cfg_t    cfg;
  aefr_result_t res, out_r, skid_r;
  logic         res_valid, accept, push, pop;
  logic         out_v_r, skid_v_r;

  aefr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = ~skid_v_r;
  assign accept      = in_ch.valid & in_ch.ready;

  aefr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_en    (accept),
    .operation  (in_ch.operation),
    .rx_byte    (in_ch.rx_byte),
    .reset_code (in_ch.reset_code),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign push = res_valid;
  assign pop  = out_v_r & out_ch.ready;

  // Result queue: output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || pop) begin
        if (skid_v_r) begin
          out_r    <= skid_r;
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_r   <= res;
          out_v_r <= push;
        end
      end else if (push) begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end
  end

  // Output channel
  assign out_ch.valid           = out_v_r;
  assign out_ch.tx_valid        = out_r.tx_valid;
  assign out_ch.tx_command      = out_r.tx_command;
  assign out_ch.frame_good      = out_r.frame_good;
  assign out_ch.abs_position    = out_r.abs_position;
  assign out_ch.multi_turn      = out_r.multi_turn;
  assign out_ch.status_byte     = out_r.status_byte;
  assign out_ch.alarm_byte      = out_r.alarm_byte;
  assign out_ch.crc_error_flag  = out_r.crc_error_flag;
  assign out_ch.no_ack_flag     = out_r.no_ack_flag;
  assign out_ch.reset_done      = out_r.reset_done;
  assign out_ch.crc_error_total = out_r.crc_error_total;
  assign out_ch.no_ack_total    = out_r.no_ack_total;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for abs_encoder_frame_receiver: random and directed reply bytes
// and timer ticks, APB register writes, and an item-level model that predicts every request item.
// Depends on aefr_pkg, aefr_if and the abs_encoder_frame_receiver RTL.
module testbench
  import aefr_pkg::*;
();

  localparam logic [2:0] CODE_NONE      = 3'd4;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         REPORT_MAX     = 20;

  typedef enum {REPLY_GOOD, REPLY_BAD_CHECK, REPLY_BAD_LEN} reply_kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic [2:0] code;
  } link_item_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  aefr_in_if  in_ch ();
  aefr_out_if out_ch ();

  abs_encoder_frame_receiver u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies, as last written over APB
  logic [15:0] period_cfg    = PERIOD_RST;
  logic [7:0]  noack_lim_cfg = NOACK_RST;
  logic [7:0]  crc_lim_cfg   = CRCLIM_RST;

  // Link state mirrored from the accepted items
  logic [7:0]  reply_buf [LONG_FRAME_BYTES] = '{default: 8'h00};
  logic [3:0]  rx_count    = '0;
  logic [3:0]  want_len    = RESET_LEN;
  logic [15:0] tick_cnt    = '0;
  logic [7:0]  noack_run   = '0;
  logic [7:0]  crc_run     = '0;
  logic [15:0] noack_total = '0;
  logic [15:0] crc_total   = '0;
  logic [3:0]  reset_sends = '0;
  logic [23:0] pos_q       = '0;
  logic [15:0] turns_q     = '0;
  logic [7:0]  status_q    = '0;
  logic [7:0]  alarm_q     = '0;

  aefr_result_t expected_requests [$];
  link_item_t   pending_items [$];
  link_item_t   next_item;

  // Stimulus side bookkeeping: tick phase and reply length the generator is aiming at
  logic [15:0] gen_tick = '0;
  logic [3:0]  gen_len  = RESET_LEN;
  int n_pushed        = 0;
  int n_accepted      = 0;
  int errors          = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  int hold_at         = 0;
  int hold_left       = 0;
  bit hold_fired      = 0;
  int idle_cycles     = 0;

  function automatic logic [3:0] len_for_code(input logic [2:0] code);
    if (code == CODE_READ) return LONG_LEN;
    if (code <= CODE_RESET_C) return SHORT_LEN;
    return NO_LEN;
  endfunction

  function automatic logic [7:0] xor_of(input logic [7:0] q [$]);
    logic [7:0] acc;
    acc = '0;
    foreach (q[i]) acc ^= q[i];
    return acc;
  endfunction

  // Apply one accepted item to the link state; an evaluation tick yields a request item
  task automatic track_link_state(input logic op, input logic [7:0] data,
                                  input logic [2:0] code);
    aefr_result_t res;
    logic [7:0] chk;
    logic good;
    int i;
    if (op == OP_BYTE) begin
      if (rx_count < LONG_LEN) reply_buf[rx_count] = data;
      if (rx_count != BYTE_COUNT_MAX) rx_count = rx_count + 4'd1;
      return;
    end
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt != period_cfg) return;
    tick_cnt = '0;
    good = 1'b0;
    // length zero means nothing was requested: no counting at all
    if (want_len != NO_LEN) begin
      if (rx_count != want_len) begin
        if (noack_run != 8'hFF) noack_run = noack_run + 8'd1;
        noack_total = noack_total + 16'd1;
      end else begin
        noack_run = '0;
        chk = '0;
        for (i = 0; i < int'(want_len) - 1; i++) chk ^= reply_buf[i];
        // only the short and long replies carry a usable check byte
        if (want_len == LONG_LEN || want_len == SHORT_LEN)
          good = (chk == reply_buf[want_len - 4'd1]);
        if (good) begin
          status_q = reply_buf[1];
          if (want_len == LONG_LEN) begin
            pos_q   = {reply_buf[4], reply_buf[3], reply_buf[2]};
            turns_q = {reply_buf[7], reply_buf[6]};
            alarm_q = reply_buf[9];
          end
          crc_run = '0;
        end else begin
          if (crc_run != 8'hFF) crc_run = crc_run + 8'd1;
          crc_total = crc_total + 16'd1;
        end
      end
    end
    rx_count = '0;

    // next request
    res = '0;
    res.frame_good = good;
    case (code)
      CODE_READ:    res.tx_command = CMD_READ;
      CODE_RESET_A: res.tx_command = CMD_RESET_A;
      CODE_RESET_B: res.tx_command = CMD_RESET_B;
      CODE_RESET_C: res.tx_command = CMD_RESET_C;
      default:      res.tx_command = '0;
    endcase
    res.tx_valid = (code <= CODE_RESET_C);
    if (code != CODE_READ && code <= CODE_RESET_C) begin
      reset_sends = reset_sends + 4'd1;
      if (reset_sends == RESET_REPEATS) begin
        reset_sends    = '0;
        res.reset_done = 1'b1;
      end
    end
    want_len = len_for_code(code);
    res.abs_position    = pos_q;
    res.multi_turn      = turns_q;
    res.status_byte     = status_q;
    res.alarm_byte      = alarm_q;
    res.crc_error_flag  = (crc_run >= crc_lim_cfg);
    res.no_ack_flag     = (noack_run >= noack_lim_cfg);
    res.crc_error_total = crc_total;
    res.no_ack_total    = noack_total;
    expected_requests.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    errors++;
    if (errors <= REPORT_MAX)
      $display("%0t %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_request();
    aefr_result_t want;
    if (expected_requests.size() == 0) begin
      report_mismatch("request item with none pending", '0, '0);
      return;
    end
    want = expected_requests.pop_front();
    check_field("tx_valid", 24'(out_ch.tx_valid), 24'(want.tx_valid));
    check_field("tx_command", 24'(out_ch.tx_command), 24'(want.tx_command));
    check_field("frame_good", 24'(out_ch.frame_good), 24'(want.frame_good));
    check_field("abs_position", out_ch.abs_position, want.abs_position);
    check_field("multi_turn", 24'(out_ch.multi_turn), 24'(want.multi_turn));
    check_field("status_byte", 24'(out_ch.status_byte), 24'(want.status_byte));
    check_field("alarm_byte", 24'(out_ch.alarm_byte), 24'(want.alarm_byte));
    check_field("crc_error_flag", 24'(out_ch.crc_error_flag), 24'(want.crc_error_flag));
    check_field("no_ack_flag", 24'(out_ch.no_ack_flag), 24'(want.no_ack_flag));
    check_field("reset_done", 24'(out_ch.reset_done), 24'(want.reset_done));
    check_field("crc_error_total", 24'(out_ch.crc_error_total), 24'(want.crc_error_total));
    check_field("no_ack_total", 24'(out_ch.no_ack_total), 24'(want.no_ack_total));
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Input driver: offer the next pending item when the slot is free, unless the sender idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.operation  <= OP_BYTE;
      in_ch.rx_byte    <= '0;
      in_ch.reset_code <= CODE_READ;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_link_state(in_ch.operation, in_ch.rx_byte, in_ch.reset_code);
        n_accepted <= n_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.operation  <= next_item.op;
          in_ch.rx_byte    <= next_item.data;
          in_ch.reset_code <= next_item.code;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_request();
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One long receiver hold-off so the result queue fills and the input stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_fired && hold_at != 0 && n_accepted >= hold_at) begin
      hold_left  <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("abs_encoder_frame_receiver: mismatch");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PERIOD: period_cfg    = value[15:0];
      REG_NOACK:  noack_lim_cfg = value[7:0];
      REG_CRCLIM: crc_lim_cfg   = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [15:0] period, input logic [7:0] noack_lim,
                              input logic [7:0] crc_lim);
    apb_write(REG_PERIOD, {16'd0, period});
    apb_write(REG_NOACK, {24'd0, noack_lim});
    apb_write(REG_CRCLIM, {24'd0, crc_lim});
  endtask

  // Block is idle once every pushed item is taken and every request item seen
  task automatic wait_idle();
    while (n_accepted != n_pushed || expected_requests.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_item(input logic op, input logic [7:0] data, input logic [2:0] code);
    link_item_t it;
    it.op   = op;
    it.data = data;
    it.code = code;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  task automatic push_tick(input logic [2:0] code);
    push_item(OP_TICK, 8'($urandom), code);
    gen_tick = gen_tick + 16'd1;
    if (gen_tick == period_cfg) begin
      gen_tick = '0;
      gen_len  = len_for_code(code);
    end
  endtask

  // Reply bytes, with an occasional tick that does not end the period
  task automatic push_reply(input logic [7:0] data [$]);
    foreach (data[i]) begin
      if (16'(gen_tick + 16'd1) != period_cfg && $urandom_range(7) == 0)
        push_tick(3'($urandom_range(7)));
      push_item(OP_BYTE, data[i], 3'($urandom_range(7)));
    end
  endtask

  // Ticks up to and including the evaluating one, which carries the request code
  task automatic finish_period(input logic [2:0] code);
    while (16'(gen_tick + 16'd1) != period_cfg) push_tick(3'($urandom_range(7)));
    push_tick(code);
  endtask

  function automatic logic [2:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 55) return CODE_READ;
    if (r < 85) return 3'($urandom_range(CODE_RESET_A, CODE_RESET_C));
    if (r < 95) return CODE_NONE;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic send_reply(input reply_kind_t kind);
    logic [7:0] data [$];
    logic [7:0] x;
    int n;
    if (kind == REPLY_BAD_LEN) begin
      do n = $urandom_range(0, 18); while (n == int'(gen_len));
    end else begin
      n = (gen_len == NO_LEN) ? $urandom_range(0, 4) : int'(gen_len);
    end
    repeat (n) data.push_back(8'($urandom));
    if (kind != REPLY_BAD_LEN && n > 0) begin
      void'(data.pop_back());
      x = xor_of(data);
      data.push_back((kind == REPLY_GOOD) ? x : x ^ 8'($urandom_range(1, 255)));
    end
    push_reply(data);
  endtask

  task automatic run_random(input int n);
    reply_kind_t kind;
    int stop_at;
    int r;
    stop_at = n_pushed + n;
    while (n_pushed < stop_at) begin
      r = $urandom_range(99);
      if (r < 15) begin
        // noise: loose bytes and ticks in any order
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) push_item(OP_BYTE, 8'($urandom), 3'($urandom_range(7)));
          else push_tick(3'($urandom_range(7)));
        end
      end else begin
        if (r < 75) kind = REPLY_GOOD;
        else if (r < 87) kind = REPLY_BAD_CHECK;
        else kind = REPLY_BAD_LEN;
        send_reply(kind);
        finish_period(pick_code());
      end
    end
    finish_period(pick_code());
  endtask

  // Main sequence
  initial begin
    logic [7:0] frame [$];
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_BYTE;
    in_ch.rx_byte    = '0;
    in_ch.reset_code = CODE_READ;
    out_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    sender_idle_pct = 6;
    recv_idle_pct   = 84;

    // directed, reset register values (every tick evaluates)
    // five bytes match the reset length but cannot be checked
    frame = {8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F};
    push_reply(frame);
    push_tick(CODE_READ);
    // good long reply, all-ones position and turns
    frame = {8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    frame.push_back(xor_of(frame));
    push_reply(frame);
    push_tick(CODE_RESET_A);
    // good short reply
    frame = {8'h00, 8'h80, 8'h00, 8'h00, 8'h00};
    frame.push_back(xor_of(frame));
    push_reply(frame);
    push_tick(CODE_RESET_B);
    // missing reply, then nothing requested
    push_tick(CODE_NONE);
    // bytes with nothing requested are not checked
    frame = {8'h12, 8'h34};
    push_reply(frame);
    push_tick(CODE_RESET_C);

    wait_idle();
    write_config(16'd1, 8'd1, 8'd1);
    run_random(300);
    wait_idle();
    write_config(16'($urandom_range(2, 12)), 8'($urandom_range(1, 6)),
                 8'($urandom_range(1, 6)));
    run_random(300);

    // sender mostly idle, receiver mostly ready
    wait_idle();
    sender_idle_pct = 84;
    recv_idle_pct   = 6;
    write_config(16'd3, 8'd255, 8'd255);
    run_random(300);

    // no idling; long receiver hold-off early in this phase
    wait_idle();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    write_config(16'd2, 8'd2, 8'd4);
    hold_at = n_pushed + 50;
    run_random(400);

    // no-ack run up to saturation, then a run of check failures
    wait_idle();
    write_config(16'd1, 8'd255, 8'd255);
    repeat (260) finish_period(CODE_READ);
    finish_period(CODE_RESET_A);
    repeat (20) begin
      send_reply(REPLY_BAD_CHECK);
      finish_period(3'($urandom_range(CODE_RESET_A, CODE_RESET_C)));
    end

    // long period, lowest limits
    wait_idle();
    write_config(16'd50, 8'd1, 8'd1);
    send_reply(REPLY_GOOD);
    finish_period(CODE_READ);

    wait_idle();
    if (errors == 0) begin
      $display("abs_encoder_frame_receiver: match");
    end else begin
      $display("abs_encoder_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
